[rtl/lfb_pkg.sv]
// shared constants, types and helpers of the latm frame builder
package lfb_pkg;

   localparam int unsigned MAX_UNIT_BYTES = 960;
   localparam int unsigned LEN_BITS       = 10;
   localparam int unsigned BURST_BYTES    = 15;
   localparam int unsigned BURST_BITS     = 8 * BURST_BYTES;
   localparam int unsigned COUNT_BITS     = $clog2(BURST_BYTES + 1);
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 4;

   localparam logic [10:0] SYNC_WORD       = 11'h2B7;
   // use_same_mux 0, mux_version 0, same_time_framing 1, subframes 0, programs 0, layers 0
   localparam logic [15:0] STREAM_MUX_HEAD = 16'h2000;
   localparam logic [4:0]  AOT_AAC_LC      = 5'b00010;
   localparam logic [4:0]  AOT_SBR         = 5'b00101;
   localparam logic [2:0]  GA_CONFIG_960   = 3'b100;
   localparam logic [2:0]  FRAME_LEN_TYPE  = 3'b000;
   localparam logic [7:0]  FULLNESS_MAX    = 8'hFF;
   localparam logic [7:0]  LEN_RUN_BYTE    = 8'hFF;
   localparam logic [LEN_BITS-1:0] LEN_RUN = LEN_BITS'(255);

   localparam logic                     RESET_SBR_ENABLE = 1'b0;
   localparam logic [3:0]               RESET_CORE_RATE  = 4'd5;
   localparam logic [3:0]               RESET_CHANNEL    = 4'd1;
   localparam logic [3:0]               RESET_EXT_RATE   = 4'd5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SBR_ENABLE  = 3'd0,
      CSR_CORE_RATE   = 3'd1,
      CSR_CHANNEL_CFG = 3'd2,
      CSR_EXT_RATE    = 3'd3
   } csr_index_type;

   typedef logic [COUNT_BITS-1:0] burst_count_type;

   typedef struct packed {
      logic                  valid;
      logic                  last;
      burst_count_type       count;
      logic [BURST_BITS-1:0] bytes;
   } burst_push_type;

   // number of full 0xff length bytes, length is below MAX_UNIT_BYTES here
   function automatic logic [1:0] len_runs(input logic [LEN_BITS-1:0] len);
      logic [1:0] runs;
      runs = 2'd0;
      if (len >= LEN_RUN) runs = 2'd1;
      if (len >= LEN_BITS'(2 * 255)) runs = 2'd2;
      if (len >= LEN_BITS'(3 * 255)) runs = 2'd3;
      return runs;
   endfunction

   function automatic logic [7:0] len_rem(input logic [LEN_BITS-1:0] len,
                                          input logic [1:0] runs);
      logic [LEN_BITS-1:0] rem;
      case (runs)
         2'd0:    rem = len;
         2'd1:    rem = len - LEN_RUN;
         2'd2:    rem = len - LEN_BITS'(2 * 255);
         default: rem = len - LEN_BITS'(3 * 255);
      endcase
      return rem[7:0];
   endfunction

endpackage

[rtl/lfb_ifs.sv]
// channel interfaces of the latm frame builder
interface lfb_req_if;
   logic                          valid;
   logic                          ready;
   logic [lfb_pkg::LEN_BITS-1:0]  au_length;
   logic [7:0]                    payload_byte;

   modport source(output valid, output au_length, output payload_byte, input ready);
   modport sink(input valid, input au_length, input payload_byte, output ready);
endinterface

interface lfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       frame_end;

   modport source(output valid, output stream_byte, output frame_end, input ready);
   modport sink(input valid, input stream_byte, input frame_end, output ready);
endinterface

interface lfb_csr_if;
   logic                                valid;
   logic                                ready;
   logic [lfb_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [lfb_pkg::CSR_DATA_BITS-1:0]   data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

[rtl/lfb_burst_buf.sv]
// output byte queue: takes a burst of frame bytes, hands out one word per cycle while rsp is ready
module lfb_burst_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  lfb_pkg::burst_push_type push,
   output logic                    room,
   lfb_rsp_if.source               rsp_ch
);

   logic [7:0]                         data_ff [lfb_pkg::BURST_BYTES];
   logic [7:0]                         data_in [lfb_pkg::BURST_BYTES];
   logic [lfb_pkg::BURST_BYTES-1:0]    end_ff;
   logic [lfb_pkg::BURST_BYTES-1:0]    end_in;
   lfb_pkg::burst_count_type           cnt_ff;
   lfb_pkg::burst_count_type           cnt_in;
   lfb_pkg::burst_count_type           base;
   logic                               pop;
   logic                               base_one;
   logic [lfb_pkg::BURST_BYTES-1:0]    push_ends;

   assign rsp_ch.valid       = (cnt_ff != '0);
   assign rsp_ch.stream_byte = data_ff[0];
   assign rsp_ch.frame_end   = end_ff[0];

   assign pop      = rsp_ch.valid && rsp_ch.ready;
   assign base     = cnt_ff - lfb_pkg::burst_count_type'(pop);
   assign base_one = (base == lfb_pkg::burst_count_type'(1));
   assign room     = (cnt_ff <= lfb_pkg::burst_count_type'(1));

   always_comb begin
      for (int k = 0; k < lfb_pkg::BURST_BYTES; k++) begin
         push_ends[k] = push.last &&
                        (push.count == lfb_pkg::burst_count_type'(k + 1));
      end
   end

   always_comb begin
      cnt_in = base;
      if (push.valid) begin
         cnt_in = base + push.count;
      end
   end

   for (genvar j = 0; j < lfb_pkg::BURST_BYTES; j++) begin : g_entry
      localparam logic [lfb_pkg::COUNT_BITS:0] JIDX = (lfb_pkg::COUNT_BITS + 1)'(j);
      logic [7:0] shift_byte;
      logic       shift_end;
      logic [7:0] push_byte;
      logic       push_end;

      if (j < lfb_pkg::BURST_BYTES - 1) begin : g_shift
         assign shift_byte = data_ff[j+1];
         assign shift_end  = end_ff[j+1];
      end else begin : g_hold
         assign shift_byte = data_ff[j];
         assign shift_end  = end_ff[j];
      end

      if (j > 0) begin : g_push
         assign push_byte = base_one ?
            push.bytes[lfb_pkg::BURST_BITS-1-8*(j-1) -: 8] :
            push.bytes[lfb_pkg::BURST_BITS-1-8*j -: 8];
         assign push_end  = base_one ? push_ends[j-1] : push_ends[j];
      end else begin : g_head
         assign push_byte = push.bytes[lfb_pkg::BURST_BITS-1 -: 8];
         assign push_end  = push_ends[0];
      end

      always_comb begin
         data_in[j] = data_ff[j];
         end_in[j]  = end_ff[j];
         if (JIDX < {1'b0, base}) begin
            if (pop) begin
               data_in[j] = shift_byte;
               end_in[j]  = shift_end;
            end
         end else if (push.valid &&
                      JIDX < ({1'b0, push.count} + (lfb_pkg::COUNT_BITS + 1)'(base_one))) begin
            data_in[j] = push_byte;
            end_in[j]  = push_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      end_ff  <= end_in;
   end

`ifndef SYNTH
   ap_push_room : assert property (@(posedge clock) disable iff (reset)
      push.valid |-> cnt_ff <= lfb_pkg::burst_count_type'(1))
      else $error("burst pushed without room");

   ap_cnt_max : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= lfb_pkg::burst_count_type'(lfb_pkg::BURST_BYTES))
      else $error("burst queue overflow");

   ap_drain : assert property (@(posedge clock) disable iff (reset)
      (pop && !push.valid) |=> cnt_ff == $past(cnt_ff) - lfb_pkg::burst_count_type'(1))
      else $error("queue count lost track on drain");
`endif

endmodule

[rtl/loas_latm_frame_builder.sv]
// an accepted input word passes the input register, then the output queue, before it is on rsp
// throughput: one input word per cycle inside a frame while rsp is ready, each giving one output word
// the first word of a frame releases a header burst of 10 to 14 words that the
// output queue drains one per cycle while rsp is ready; input is held while more than one word waits
// the last word of a frame gives two output words (data and zero-padded tail)
// reset: synchronous, clears frame state and queue, config returns to defaults
module loas_latm_frame_builder (
   input  logic      clock,
   input  logic      reset,
   lfb_req_if.sink   req_ch,
   lfb_rsp_if.source rsp_ch,
   lfb_csr_if.sink   csr_ch
);

   // configuration
   logic       sbr_enable_ff;
   logic [3:0] core_rate_ff;
   logic [3:0] channel_ff;
   logic [3:0] ext_rate_ff;

   // input register
   logic                         in_valid_ff;
   logic                         in_valid_in;
   logic [lfb_pkg::LEN_BITS-1:0] in_len_ff;
   logic [7:0]                   in_byte_ff;

   // frame state
   logic                         open_ff;
   logic                         open_in;
   logic                         sbr_frame_ff;
   logic                         sbr_frame_in;
   logic [5:0]                   carry_ff;
   logic [5:0]                   carry_in;
   logic [lfb_pkg::LEN_BITS-1:0] left_ff;
   logic [lfb_pkg::LEN_BITS-1:0] left_in;

   logic                         req_accept;
   logic                         room;
   logic                         advance;
   logic                         len_ok;
   logic                         is_last;
   logic [1:0]                   runs;
   logic [7:0]                   rem;
   logic [39:0]                  tail;
   logic [12:0]                  total;
   lfb_pkg::burst_count_type     head_bytes;
   lfb_pkg::burst_push_type      push;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !in_valid_ff || room;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign advance      = in_valid_ff && room;
   assign in_valid_in  = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         sbr_enable_ff <= lfb_pkg::RESET_SBR_ENABLE;
         core_rate_ff  <= lfb_pkg::RESET_CORE_RATE;
         channel_ff    <= lfb_pkg::RESET_CHANNEL;
         ext_rate_ff   <= lfb_pkg::RESET_EXT_RATE;
      end else if (csr_ch.valid) begin
         case (lfb_pkg::csr_index_type'(csr_ch.index))
            lfb_pkg::CSR_SBR_ENABLE:  sbr_enable_ff <= csr_ch.data[0];
            lfb_pkg::CSR_CORE_RATE:   core_rate_ff  <= csr_ch.data[3:0];
            lfb_pkg::CSR_CHANNEL_CFG: channel_ff    <= csr_ch.data[3:0];
            lfb_pkg::CSR_EXT_RATE:    ext_rate_ff   <= csr_ch.data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_len_ff  <= req_ch.au_length;
         in_byte_ff <= req_ch.payload_byte;
      end
   end

   assign len_ok = (in_len_ff != '0) &&
                   (in_len_ff < lfb_pkg::LEN_BITS'(lfb_pkg::MAX_UNIT_BYTES));
   assign runs   = lfb_pkg::len_runs(in_len_ff);
   assign rem    = lfb_pkg::len_rem(in_len_ff, runs);
   assign total  = 13'(in_len_ff) + 13'(runs) + (sbr_enable_ff ? 13'd8 : 13'd7);

   // payload length info runs, then remainder, then the first payload byte
   always_comb begin
      case (runs)
         2'd0:    tail = {rem, in_byte_ff, 24'd0};
         2'd1:    tail = {lfb_pkg::LEN_RUN_BYTE, rem, in_byte_ff, 16'd0};
         2'd2:    tail = {{2{lfb_pkg::LEN_RUN_BYTE}}, rem, in_byte_ff, 8'd0};
         default: tail = {{3{lfb_pkg::LEN_RUN_BYTE}}, rem, in_byte_ff};
      endcase
   end

   always_comb begin
      push         = '0;
      open_in      = open_ff;
      sbr_frame_in = sbr_frame_ff;
      carry_in     = carry_ff;
      left_in      = left_ff;
      is_last      = 1'b0;
      head_bytes   = '0;
      if (advance) begin
         if (!open_ff) begin
            if (len_ok) begin
               is_last = (in_len_ff == lfb_pkg::LEN_BITS'(1));
               if (sbr_enable_ff) begin
                  push.bytes = {lfb_pkg::SYNC_WORD, total, lfb_pkg::STREAM_MUX_HEAD,
                                lfb_pkg::AOT_SBR, core_rate_ff, channel_ff, ext_rate_ff,
                                lfb_pkg::AOT_AAC_LC, lfb_pkg::GA_CONFIG_960,
                                lfb_pkg::FRAME_LEN_TYPE, lfb_pkg::FULLNESS_MAX, 2'b00,
                                tail, {(lfb_pkg::BURST_BITS - 118){1'b0}}};
                  head_bytes = lfb_pkg::burst_count_type'(11) +
                               lfb_pkg::burst_count_type'(runs);
                  carry_in   = in_byte_ff[5:0];
               end else begin
                  push.bytes = {lfb_pkg::SYNC_WORD, total, lfb_pkg::STREAM_MUX_HEAD,
                                lfb_pkg::AOT_AAC_LC, core_rate_ff, channel_ff,
                                lfb_pkg::GA_CONFIG_960,
                                lfb_pkg::FRAME_LEN_TYPE, lfb_pkg::FULLNESS_MAX, 2'b00,
                                tail, {(lfb_pkg::BURST_BITS - 109){1'b0}}};
                  head_bytes = lfb_pkg::burst_count_type'(10) +
                               lfb_pkg::burst_count_type'(runs);
                  carry_in   = {1'b0, in_byte_ff[4:0]};
               end
               push.valid   = 1'b1;
               push.last    = is_last;
               push.count   = head_bytes + lfb_pkg::burst_count_type'(is_last);
               sbr_frame_in = sbr_enable_ff;
               left_in      = in_len_ff - lfb_pkg::LEN_BITS'(1);
               open_in      = !is_last;
            end
         end else begin
            is_last = (left_ff == lfb_pkg::LEN_BITS'(1));
            if (sbr_frame_ff) begin
               push.bytes = {carry_ff[5:0], in_byte_ff,
                             {(lfb_pkg::BURST_BITS - 14){1'b0}}};
               carry_in   = in_byte_ff[5:0];
            end else begin
               push.bytes = {carry_ff[4:0], in_byte_ff,
                             {(lfb_pkg::BURST_BITS - 13){1'b0}}};
               carry_in   = {1'b0, in_byte_ff[4:0]};
            end
            push.valid = 1'b1;
            push.last  = is_last;
            push.count = is_last ? lfb_pkg::burst_count_type'(2) :
                                   lfb_pkg::burst_count_type'(1);
            left_in    = left_ff - lfb_pkg::LEN_BITS'(1);
            open_in    = !is_last;
         end
         // frame closes: drop the leftover bits, they went out in the padded word
         if (is_last) begin
            carry_in = '0;
            left_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         sbr_frame_ff <= 1'b0;
         carry_ff     <= '0;
         left_ff      <= '0;
      end else begin
         open_ff      <= open_in;
         sbr_frame_ff <= sbr_frame_in;
         carry_ff     <= carry_in;
         left_ff      <= left_in;
      end
   end

   lfb_burst_buf u_burst_buf (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTH
   ap_open_left : assert property (@(posedge clock) disable iff (reset)
      open_ff |-> left_ff != '0)
      else $error("open frame with no bytes left");

   ap_closed_carry : assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> carry_ff == '0)
      else $error("leftover bits outside a frame");

   ap_open_rise : assert property (@(posedge clock) disable iff (reset)
      $rose(open_ff) |-> $past(advance))
      else $error("frame opened without an input word");
`endif

endmodule
